// ----- rtl/spq_pkg.sv -----
// spq_pkg: shared constants, codes and types for the sorted priority queue.
// Used by spq_store, spq_ctrl and sorted_priority_queue; no dependencies.

package spq_pkg;

   // default geometry
   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 4;

   // fixed field widths of the request and response beats
   localparam int VALUE_W  = 8;
   localparam int PRIO_W   = 4;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_FRONT,
      ST_REM_RD,
      ST_REM_WR,
      ST_DONE
   } state_type;

   // one finished response, handed from the sequencer to the output register
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  data;
      logic                data_valid;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

// ----- rtl/spq_store.sv -----
// spq_store: entry memory of the queue, one write and one registered read port.
// Depends on spq_pkg for default geometry and the value width.

module spq_store import spq_pkg::*; #(
   parameter int  CAPACITY      = CAPACITY_DEF,
   parameter int  PRIORITY_BITS = PRIORITY_BITS_DEF,
   localparam int IW            = $clog2(CAPACITY),
   localparam int EW            = PRIORITY_BITS + VALUE_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spq_ctrl.sv -----
// spq_ctrl: sequencer that walks the entry store one entry per step, using one
// priority comparator for insert and one move path for remove. Depends on spq_pkg.

module spq_ctrl import spq_pkg::*; #(
   parameter int  CAPACITY      = CAPACITY_DEF,
   parameter int  PRIORITY_BITS = PRIORITY_BITS_DEF,
   localparam int IW            = $clog2(CAPACITY),
   localparam int CW            = $clog2(CAPACITY + 1),
   localparam int EW            = PRIORITY_BITS + VALUE_W
) (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [REQ_W-1:0]   req_type,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [PRIO_W-1:0]  req_priority_req,
   // result side
   input  logic               rsp_free,
   output logic               done,
   output rsp_type            result,
   // entry store
   output logic               wr_en,
   output logic [IW-1:0]      wr_addr,
   output logic [EW-1:0]      wr_data,
   output logic               rd_en,
   output logic [IW-1:0]      rd_addr,
   input  logic [EW-1:0]      rd_data
);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [REQ_W-1:0]         op_ff, op_in;
   logic [VALUE_W-1:0]       val_ff, val_in;
   logic [PRIORITY_BITS-1:0] pri_ff, pri_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [VALUE_W-1:0]       data_ff, data_in;
   logic                     dvalid_ff, dvalid_in;

   logic                     req_fire;
   logic                     is_front;
   logic                     full;
   logic                     empty;
   logic                     move_up;
   logic [PRIORITY_BITS-1:0] rd_pri;
   logic [EW-1:0]            new_entry;

   assign req_fire  = req_valid && req_ready;
   assign is_front  = (req_type == REQ_REMOVE) || (req_type == REQ_PEEK);
   assign full      = (count_ff >= CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign rd_pri    = rd_data[EW-1:VALUE_W];
   assign new_entry = {pri_ff, val_ff};
   // shared comparator: stored entry goes behind the new one only if strictly later
   assign move_up   = (rd_pri > pri_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      val_ff    <= val_in;
      pri_ff    <= pri_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      dvalid_ff <= dvalid_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority case (1'b1)
                  (req_type == REQ_INSERT) && !full: state_in = ST_INS_RD;
                  is_front && !empty:                 state_in = ST_FRONT;
                  default:                            state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_RD: begin
            state_in = (idx_ff == '0) ? ST_DONE : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = move_up ? ST_INS_RD : ST_DONE;
         end
         ST_FRONT: begin
            state_in = (op_ff == REQ_REMOVE) ? ST_REM_RD : ST_DONE;
         end
         ST_REM_RD: begin
            state_in = (idx_ff >= count_ff) ? ST_DONE : ST_REM_WR;
         end
         ST_REM_WR: begin
            state_in = ST_REM_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // working register updates
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      pri_in    = pri_ff;
      status_in = status_ff;
      data_in   = data_ff;
      dvalid_in = dvalid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_type;
               val_in    = req_value;
               pri_in    = PRIORITY_BITS'(req_priority_req);
               status_in = STATUS_OK;
               data_in   = '0;
               dvalid_in = 1'b0;
               idx_in    = count_ff;
               if ((req_type == REQ_INSERT) && full) begin
                  status_in = STATUS_FULL;
               end else if (is_front && empty) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_INS_CMP: begin
            if (move_up) begin
               idx_in = idx_ff - CW'(1);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_FRONT: begin
            data_in   = rd_data[VALUE_W-1:0];
            dvalid_in = 1'b1;
            idx_in    = CW'(1);
         end
         ST_REM_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         ST_REM_WR: begin
            idx_in = idx_ff + CW'(1);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // store access and handshake outputs
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IW-1:0];
      wr_data   = new_entry;
      rd_en     = 1'b0;
      rd_addr   = '0;
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_en     = req_fire && is_front && !empty;
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = IW'(idx_ff - CW'(1));
            end
         end
         ST_INS_CMP: begin
            // shift the later entry up one slot, or drop the new one in
            wr_en   = 1'b1;
            wr_data = move_up ? rd_data : new_entry;
         end
         ST_FRONT: begin
         end
         ST_REM_RD: begin
            rd_en   = (idx_ff < count_ff);
            rd_addr = idx_ff[IW-1:0];
         end
         ST_REM_WR: begin
            wr_en   = 1'b1;
            wr_addr = IW'(idx_ff - CW'(1));
            wr_data = rd_data;
         end
         ST_DONE: begin
            done = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign result.status     = status_ff;
   assign result.data       = data_ff;
   assign result.data_valid = dvalid_ff;
   assign result.occupancy  = OCC_W'(count_ff);

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// sorted_priority_queue: top level, sequencer plus entry store plus response register.
// Depends on spq_pkg, spq_store and spq_ctrl.
//
//   channel | ports                                               | dir
//   --------+-----------------------------------------------------+-----
//   req     | req_valid/ready, req_type, req_value,               | in
//           | req_priority_req                                    |
//   rsp     | rsp_valid/ready, rsp_status, rsp_data,              | out
//           | rsp_data_valid, rsp_occupancy                       |
//
// One beat at a time; req_ready is low while a beat is being worked.
// Insert moves each stored entry of later priority up a slot, then writes the new one
// in (paced by the store's registered read port). Remove reads the front and moves
// the rest down; peek reads it. Full insert, empty remove/peek, unused code just finish.
// Finishing waits while the response register still holds an unread beat; a new beat
// is taken while the latest result waits. Reset empties the queue, not the store.

module sorted_priority_queue import spq_pkg::*; #(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [PRIO_W-1:0]   req_priority_req,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_data,
   output logic                rsp_data_valid,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int IW = $clog2(CAPACITY);
   localparam int EW = PRIORITY_BITS + VALUE_W;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          done;
   logic          rsp_free;
   rsp_type       result;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   spq_store #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_ctrl #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_free         (rsp_free),
      .done             (done),
      .result           (result),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   // response register: free once empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_data       = rsp_ff.data;
   assign rsp_data_valid = rsp_ff.data_valid;
   assign rsp_occupancy  = rsp_ff.occupancy;

`ifndef SYNTH
   // busy right after a request beat is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat was still in work");

   // a full answer reports a full queue
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_occupancy == OCC_W'(CAPACITY))
      else $error("full status with wrong occupancy");

   // an empty answer reports an empty queue
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_occupancy == '0)
      else $error("empty status with nonzero occupancy");

   // front data only comes with an ok status
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_status == STATUS_OK)
      else $error("front data flagged on a failed request");
`endif

endmodule
